// ===== rtl/core/dkc_pkg.sv =====
// Package for the dead key compose translator.
// Holds sizes, event and action codes, key codes and the layout ROM.
// No dependencies.
package dkc_pkg;

    localparam int ENTRY_COUNT        = 12;
    localparam int OUTCOMES_PER_ENTRY = 6;
    localparam int SWALLOW_DEPTH      = 16;

    localparam int ROM_ROWS    = 16;
    localparam int ROM_COLS    = 8;
    localparam int ENTRY_LIMIT = (ENTRY_COUNT < ROM_ROWS) ? ENTRY_COUNT : ROM_ROWS;
    localparam int OUT_LIMIT   = (OUTCOMES_PER_ENTRY < ROM_COLS) ? OUTCOMES_PER_ENTRY : ROM_COLS;

    localparam int SW_IDX_W = $clog2(SWALLOW_DEPTH);
    localparam int SW_CNT_W = $clog2(SWALLOW_DEPTH + 1);

    localparam logic [1:0] KIND_DOWN   = 2'd0;
    localparam logic [1:0] KIND_UP     = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_CHAR      = 3'd1;
    localparam logic [2:0] ACT_MENU_TAP  = 3'd2;
    localparam logic [2:0] ACT_CTRL_DOWN = 3'd3;
    localparam logic [2:0] ACT_CTRL_UP   = 3'd4;

    localparam logic [7:0] KEY_APPS  = 8'h5D;
    localparam logic [7:0] KEY_RALT  = 8'hA5;
    localparam logic [7:0] KEY_SPACE = 8'h20;
    localparam logic [7:0] KEY_ALNUM_LO = 8'h30;
    localparam logic [7:0] KEY_ALNUM_HI = 8'h5A;
    localparam logic [7:0] KEY_PAD_LO   = 8'h60;
    localparam logic [7:0] KEY_PAD_HI   = 8'h6F;
    localparam logic [7:0] KEY_OEM_LO   = 8'hBA;
    localparam logic [7:0] KEY_OEM_HI   = 8'hFE;

    localparam logic [15:0] CH_NBSP  = 16'h00A0;
    localparam logic [15:0] CH_LAQUO = 16'h00AB;
    localparam logic [15:0] CH_RAQUO = 16'h00BB;

    typedef struct packed {
        logic [7:0]  key;
        logic [15:0] plain;
        logic [15:0] shifted;
        logic [3:0]  n;
    } entry_t;

    typedef struct packed {
        logic [7:0]  key;
        logic [15:0] plain;
        logic [15:0] shifted;
    } outcome_t;

    typedef struct packed {
        logic        two;
        logic [15:0] c0;
        logic [15:0] c1;
    } char_pair_t;

    function automatic entry_t rom_entry(logic [3:0] row);
        entry_t e;
        e = '0;
        case (row)
            4'd0:  e = '{8'h45, 16'h00E9, 16'h00C9, 4'd0};
            4'd1:  e = '{8'h41, 16'h00E0, 16'h00C0, 4'd0};
            4'd2:  e = '{8'h43, 16'h00E7, 16'h00C7, 4'd0};
            4'd3:  e = '{8'hBA, 16'h2026, 16'h2026, 4'd0};
            4'd4:  e = '{8'hDB, 16'h00AB, 16'h00AB, 4'd0};
            4'd5:  e = '{8'hDD, 16'h00BB, 16'h00BB, 4'd0};
            4'd6:  e = '{8'h20, 16'h00A0, 16'h00A0, 4'd0};
            4'd7:  e = '{8'h55, 16'h0060, 16'h0060, 4'd6};
            4'd8:  e = '{8'h49, 16'h005E, 16'h005E, 4'd6};
            4'd9:  e = '{8'h4F, 16'h00A8, 16'h00A8, 4'd6};
            4'd10: e = '{8'h50, 16'h00B4, 16'h00B4, 4'd6};
            4'd11: e = '{8'h4E, 16'h007E, 16'h007E, 4'd2};
            default: e = '0;
        endcase
        return e;
    endfunction

    function automatic outcome_t rom_outcome(logic [3:0] row, logic [2:0] col);
        outcome_t o;
        logic [7:0] k;
        o = '0;
        case (col)
            3'd0: k = 8'h41;
            3'd1: k = 8'h45;
            3'd2: k = 8'h49;
            3'd3: k = 8'h4F;
            3'd4: k = 8'h55;
            3'd5: k = 8'h20;
            default: k = 8'h00;
        endcase
        case (row)
            4'd7: begin
                case (col)
                    3'd0: o = '{k, 16'h00E0, 16'h00C0};
                    3'd1: o = '{k, 16'h00E8, 16'h00C8};
                    3'd2: o = '{k, 16'h00EC, 16'h00CC};
                    3'd3: o = '{k, 16'h00F2, 16'h00D2};
                    3'd4: o = '{k, 16'h00F9, 16'h00D9};
                    3'd5: o = '{k, 16'h0060, 16'h0060};
                    default: o = '0;
                endcase
            end
            4'd8: begin
                case (col)
                    3'd0: o = '{k, 16'h00E2, 16'h00C2};
                    3'd1: o = '{k, 16'h00EA, 16'h00CA};
                    3'd2: o = '{k, 16'h00EE, 16'h00CE};
                    3'd3: o = '{k, 16'h00F4, 16'h00D4};
                    3'd4: o = '{k, 16'h00FB, 16'h00DB};
                    3'd5: o = '{k, 16'h005E, 16'h005E};
                    default: o = '0;
                endcase
            end
            4'd9: begin
                case (col)
                    3'd0: o = '{k, 16'h00E4, 16'h00C4};
                    3'd1: o = '{k, 16'h00EB, 16'h00CB};
                    3'd2: o = '{k, 16'h00EF, 16'h00CF};
                    3'd3: o = '{k, 16'h00F6, 16'h00D6};
                    3'd4: o = '{k, 16'h00FC, 16'h00DC};
                    3'd5: o = '{k, 16'h00A8, 16'h00A8};
                    default: o = '0;
                endcase
            end
            4'd10: begin
                case (col)
                    3'd0: o = '{k, 16'h00E1, 16'h00C1};
                    3'd1: o = '{k, 16'h00E9, 16'h00C9};
                    3'd2: o = '{k, 16'h00ED, 16'h00CD};
                    3'd3: o = '{k, 16'h00F3, 16'h00D3};
                    3'd4: o = '{k, 16'h00FA, 16'h00DA};
                    3'd5: o = '{k, 16'h00B4, 16'h00B4};
                    default: o = '0;
                endcase
            end
            4'd11: begin
                case (col)
                    3'd0: o = '{8'h4E, 16'h00F1, 16'h00D1};
                    3'd1: o = '{8'h20, 16'h007E, 16'h007E};
                    default: o = '0;
                endcase
            end
            default: o = '0;
        endcase
        return o;
    endfunction

endpackage

// ===== rtl/core/dead_key_compose_translator_unit.sv =====
// Dead key compose translator, top level.
// An accepted event is registered, evaluated in ST_EVAL and loaded into the output buffer
// in ST_EMIT once that buffer is empty; a key release that searches the swallow list reads
// one list entry per cycle in ST_SRCH and ST_SHIFT. A new event is accepted only in ST_IDLE.
// Reset (aresetn low, synchronous): flags, pending dead key and list count cleared;
// the list memory is not cleared, only entries below the count are read. Uses dkc_pkg.
module dead_key_compose_translator_unit
    import dkc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // key_code[7:0], shift[8], left_ctrl_down[9], remote_session[10]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // char_code[15:0], swallow[16]
    output logic [2:0]  m_tuser,   // action[2:0]
    output logic        m_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_SRCH  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [1:0] in_kind_reg;
    logic [7:0] in_key_reg;
    logic       in_shift_reg, in_lctrl_reg, in_remote_reg;

    logic [3:0] pend_entry_reg, pend_entry_next;
    logic       pend_valid_reg, pend_valid_next;
    logic       ralt_reg, ralt_next;
    logic       menu_reg, menu_next;
    logic       armed_reg, armed_next;
    logic       forced_reg, forced_next;
    logic [SW_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SW_IDX_W-1:0] rd_idx_reg, rd_idx_next;

    logic [2:0]  st_act0_reg, st_act0_next, st_act1_reg, st_act1_next;
    logic [15:0] st_chr0_reg, st_chr0_next, st_chr1_reg, st_chr1_next;
    logic        st_two_reg, st_two_next, st_sw_reg, st_sw_next;

    logic [2:0]  ob_act0_reg, ob_act1_reg;
    logic [15:0] ob_chr0_reg, ob_chr1_reg;
    logic        ob_sw_reg;
    logic [1:0]  ob_cnt_reg;

    logic [7:0]          sw_mem [SWALLOW_DEPTH];
    logic                mem_we, mem_re;
    logic [SW_IDX_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]          mem_wdata, mem_rdata_reg;

    entry_t     ent, pend_row, ent_row;
    outcome_t   oc, oc_hit;
    logic       ent_found, oc_found, is_char, emit, rec, done;
    logic [3:0] ent_idx, ent_olim, pend_olim;
    logic [SW_CNT_W-1:0] nxt_idx;
    char_pair_t ch;

    function automatic char_pair_t emit_char(logic [15:0] c);
        char_pair_t p;
        p = '{1'b0, c, 16'h0000};
        if (c == CH_RAQUO) begin
            p = '{1'b1, CH_NBSP, c};
        end else if (c == CH_LAQUO) begin
            p = '{1'b1, c, CH_NBSP};
        end
        return p;
    endfunction

    // ROM lookups on the latched key
    always_comb begin
        ent_found = 1'b0;
        ent_idx   = '0;
        ent       = '0;
        ent_row   = '0;
        for (int i = 0; i < ROM_ROWS; i++) begin
            ent_row = rom_entry(4'(i));
            if (i < ENTRY_LIMIT && !ent_found && ent_row.key == in_key_reg) begin
                ent_found = 1'b1;
                ent_idx   = 4'(i);
                ent       = ent_row;
            end
        end
        ent_olim  = (ent.n < 4'(OUT_LIMIT)) ? ent.n : 4'(OUT_LIMIT);
        pend_row  = rom_entry(pend_entry_reg);
        pend_olim = (pend_row.n < 4'(OUT_LIMIT)) ? pend_row.n : 4'(OUT_LIMIT);
        oc_found  = 1'b0;
        oc_hit    = '0;
        oc        = '0;
        for (int c = 0; c < ROM_COLS; c++) begin
            oc = rom_outcome(pend_entry_reg, 3'(c));
            if (c < int'(pend_olim) && !oc_found && oc.key == in_key_reg) begin
                oc_found = 1'b1;
                oc_hit   = oc;
            end
        end
        is_char = (in_key_reg inside {[KEY_ALNUM_LO:KEY_ALNUM_HI], [KEY_PAD_LO:KEY_PAD_HI],
                                      [KEY_OEM_LO:KEY_OEM_HI], KEY_SPACE});
    end

    assign nxt_idx = SW_CNT_W'(rd_idx_reg) + SW_CNT_W'(1);

    always_comb begin
        state_next      = state_reg;
        pend_entry_next = pend_entry_reg;
        pend_valid_next = pend_valid_reg;
        ralt_next       = ralt_reg;
        menu_next       = menu_reg;
        armed_next      = armed_reg;
        forced_next     = forced_reg;
        cnt_next        = cnt_reg;
        rd_idx_next     = rd_idx_reg;
        st_act0_next    = st_act0_reg;
        st_act1_next    = st_act1_reg;
        st_chr0_next    = st_chr0_reg;
        st_chr1_next    = st_chr1_reg;
        st_two_next     = st_two_reg;
        st_sw_next      = st_sw_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg[SW_IDX_W-1:0];
        mem_wdata       = in_key_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        emit            = 1'b0;
        rec             = 1'b0;
        done            = 1'b0;
        ch              = '0;
        if (state_reg == ST_EVAL || state_reg == ST_SRCH || state_reg == ST_SHIFT) begin
            st_act0_next = ACT_NONE;
            st_act1_next = ACT_NONE;
            st_chr0_next = '0;
            st_chr1_next = '0;
            st_two_next  = 1'b0;
            st_sw_next   = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                done = 1'b1;
                case (in_kind_reg)
                    KIND_DOWN: begin
                        if (in_key_reg == KEY_APPS && !in_remote_reg) begin
                            menu_next  = 1'b1;
                            armed_next = 1'b1;
                            st_sw_next = 1'b1;
                        end else begin
                            armed_next = 1'b0;
                            if (in_key_reg == KEY_RALT) begin
                                ralt_next = 1'b1;
                                if (!in_lctrl_reg) begin
                                    forced_next  = 1'b1;
                                    st_act0_next = ACT_CTRL_DOWN;
                                end
                            end else if (is_char) begin
                                if (!pend_valid_reg) begin
                                    if ((ralt_reg || menu_reg) && ent_found) begin
                                        if (ent_olim == 4'd0) begin
                                            emit = 1'b1;
                                            ch   = emit_char(in_shift_reg ? ent.shifted : ent.plain);
                                        end else begin
                                            pend_entry_next = ent_idx;
                                            pend_valid_next = 1'b1;
                                        end
                                        rec        = 1'b1;
                                        st_sw_next = 1'b1;
                                    end
                                end else begin
                                    pend_valid_next = 1'b0;
                                    pend_entry_next = '0;
                                    emit            = 1'b1;
                                    if (oc_found) begin
                                        ch = emit_char(in_shift_reg ? oc_hit.shifted : oc_hit.plain);
                                        rec        = 1'b1;
                                        st_sw_next = 1'b1;
                                    end else begin
                                        ch = emit_char(in_shift_reg ? pend_row.shifted
                                                                    : pend_row.plain);
                                    end
                                end
                            end
                        end
                    end
                    KIND_UP: begin
                        if (in_key_reg == KEY_APPS && !in_remote_reg) begin
                            menu_next  = 1'b0;
                            armed_next = 1'b0;
                            st_sw_next = 1'b1;
                            if (menu_reg && armed_reg) begin
                                st_act0_next = ACT_MENU_TAP;
                            end
                        end else if (in_key_reg == KEY_RALT) begin
                            ralt_next = 1'b0;
                            if (forced_reg) begin
                                forced_next  = 1'b0;
                                st_act0_next = ACT_CTRL_UP;
                            end
                        end else if (cnt_reg != '0) begin
                            mem_re      = 1'b1;
                            mem_raddr   = '0;
                            rd_idx_next = '0;
                            done        = 1'b0;
                            state_next  = ST_SRCH;
                        end
                    end
                    KIND_CANCEL: begin
                        pend_valid_next = 1'b0;
                        pend_entry_next = '0;
                    end
                    default: ;
                endcase
                if (emit) begin
                    st_act0_next = ACT_CHAR;
                    st_chr0_next = ch.c0;
                    st_two_next  = ch.two;
                    st_act1_next = ch.two ? ACT_CHAR : ACT_NONE;
                    st_chr1_next = ch.c1;
                end
                if (rec && cnt_reg < SW_CNT_W'(SWALLOW_DEPTH)) begin
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + SW_CNT_W'(1);
                end
            end
            ST_SRCH: begin
                if (mem_rdata_reg == in_key_reg) begin
                    if (nxt_idx < cnt_reg) begin
                        mem_re      = 1'b1;
                        mem_raddr   = nxt_idx[SW_IDX_W-1:0];
                        rd_idx_next = nxt_idx[SW_IDX_W-1:0];
                        state_next  = ST_SHIFT;
                    end else begin
                        cnt_next   = cnt_reg - SW_CNT_W'(1);
                        st_sw_next = 1'b1;
                        done       = 1'b1;
                    end
                end else if (nxt_idx < cnt_reg) begin
                    mem_re      = 1'b1;
                    mem_raddr   = nxt_idx[SW_IDX_W-1:0];
                    rd_idx_next = nxt_idx[SW_IDX_W-1:0];
                end else begin
                    done = 1'b1;
                end
            end
            ST_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = rd_idx_reg - SW_IDX_W'(1);
                mem_wdata = mem_rdata_reg;
                if (nxt_idx < cnt_reg) begin
                    mem_re      = 1'b1;
                    mem_raddr   = nxt_idx[SW_IDX_W-1:0];
                    rd_idx_next = nxt_idx[SW_IDX_W-1:0];
                end else begin
                    cnt_next   = cnt_reg - SW_CNT_W'(1);
                    st_sw_next = 1'b1;
                    done       = 1'b1;
                end
            end
            ST_EMIT: begin
                if (ob_cnt_reg == 2'd0) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (done) begin
            state_next = ST_EMIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sw_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= sw_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_entry_reg <= '0;
            pend_valid_reg <= 1'b0;
            ralt_reg       <= 1'b0;
            menu_reg       <= 1'b0;
            armed_reg      <= 1'b0;
            forced_reg     <= 1'b0;
            cnt_reg        <= '0;
            ob_cnt_reg     <= 2'd0;
        end else begin
            state_reg      <= state_next;
            pend_entry_reg <= pend_entry_next;
            pend_valid_reg <= pend_valid_next;
            ralt_reg       <= ralt_next;
            menu_reg       <= menu_next;
            armed_reg      <= armed_next;
            forced_reg     <= forced_next;
            cnt_reg        <= cnt_next;
            if (state_reg == ST_EMIT && ob_cnt_reg == 2'd0) begin
                ob_cnt_reg <= st_two_reg ? 2'd2 : 2'd1;
            end else if (m_tvalid && m_tready) begin
                ob_cnt_reg <= ob_cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg  <= rd_idx_next;
        st_act0_reg <= st_act0_next;
        st_act1_reg <= st_act1_next;
        st_chr0_reg <= st_chr0_next;
        st_chr1_reg <= st_chr1_next;
        st_two_reg  <= st_two_next;
        st_sw_reg   <= st_sw_next;
        if (s_tvalid && s_tready) begin
            in_kind_reg   <= s_tuser;
            in_key_reg    <= s_tdata[7:0];
            in_shift_reg  <= s_tdata[8];
            in_lctrl_reg  <= s_tdata[9];
            in_remote_reg <= s_tdata[10];
        end
        if (state_reg == ST_EMIT && ob_cnt_reg == 2'd0) begin
            ob_act0_reg <= st_act0_reg;
            ob_chr0_reg <= st_chr0_reg;
            ob_act1_reg <= st_act1_reg;
            ob_chr1_reg <= st_chr1_reg;
            ob_sw_reg   <= st_sw_reg;
        end else if (m_tvalid && m_tready) begin
            ob_act0_reg <= ob_act1_reg;
            ob_chr0_reg <= ob_chr1_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (ob_cnt_reg != 2'd0);
    assign m_tlast  = (ob_cnt_reg == 2'd1);
    assign m_tuser  = ob_act0_reg;
    assign m_tdata  = {7'b0, ob_sw_reg, ob_chr0_reg};

endmodule

// ===== rtl/core/dkc_checker.sv =====
// Port-level checker for the dead key compose translator, bound to the top level.
// Uses dkc_pkg action codes.
module dkc_checker
    import dkc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |->
            m_tuser == ACT_CHAR ##1 m_tvalid && m_tlast && m_tuser == ACT_CHAR
                                    && m_tdata[16] == $past(m_tdata[16]))
        else $error("second result of an event malformed");

    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ACT_CHAR |-> m_tdata[15:0] == 16'h0000 && m_tlast)
        else $error("non-character result carries a code");

endmodule

bind dead_key_compose_translator_unit dkc_checker u_dkc_checker (.*);

// ===== bench/dead_key_compose_translator_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for dead_key_compose_translator_unit: directed and random key events,
// with results predicted by a behavioral translator and compared per transaction.
// Depends on dkc_pkg and the dead_key_compose_translator_unit RTL.
module dead_key_compose_translator_unit_test;
    import dkc_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_EVENTS   = 1100;
    localparam int RELEASE_WAIT    = 2 * SWALLOW_DEPTH + 8;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] char_code;
        logic        swallow;
        logic        last;
    } key_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // key_code[7:0], shift[8], left_ctrl_down[9], remote_session[10]
    logic [1:0]  s_tuser = '0;    // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // char_code[15:0], swallow[16]
    logic [2:0]  m_tuser;         // action[2:0]
    logic        m_tlast;

    dead_key_compose_translator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // translator state
    int          dead_row;
    bit          dead_armed;
    bit          ralt_down;
    bit          menu_down;
    bit          menu_tap;
    bit          lctrl_forced;
    logic [7:0]  eaten_keys[$];
    key_result_t event_acts[$];
    key_result_t due_results[$];

    int errors = 0;
    int events_sent = 0;
    int burst_left = 1;
    int hold_request = 0;

    // layout tables
    function automatic logic [7:0] row_key(int r);
        case (r)
            0: return 8'h45;
            1: return 8'h41;
            2: return 8'h43;
            3: return 8'hBA;
            4: return 8'hDB;
            5: return 8'hDD;
            6: return 8'h20;
            7: return 8'h55;
            8: return 8'h49;
            9: return 8'h4F;
            10: return 8'h50;
            11: return 8'h4E;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [15:0] row_char(int r, bit sh);
        case (r)
            0: return sh ? 16'h00C9 : 16'h00E9;
            1: return sh ? 16'h00C0 : 16'h00E0;
            2: return sh ? 16'h00C7 : 16'h00E7;
            3: return 16'h2026;
            4: return CH_LAQUO;
            5: return CH_RAQUO;
            6: return CH_NBSP;
            7: return 16'h0060;
            8: return 16'h005E;
            9: return 16'h00A8;
            10: return 16'h00B4;
            11: return 16'h007E;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic int outcome_count(int r);
        int n;
        n = (r >= 7 && r <= 10) ? 6 : (r == 11) ? 2 : 0;
        return (n < OUT_LIMIT) ? n : OUT_LIMIT;
    endfunction

    function automatic logic [7:0] outcome_key(int r, int c);
        if (r == 11)
            return (c == 0) ? 8'h4E : KEY_SPACE;
        case (c)
            0: return 8'h41;
            1: return 8'h45;
            2: return 8'h49;
            3: return 8'h4F;
            4: return 8'h55;
            default: return KEY_SPACE;
        endcase
    endfunction

    // accented vowels: shifted form is the plain one minus 0x20
    function automatic logic [15:0] outcome_char(int r, int c, bit sh);
        logic [39:0] vowels;
        logic [7:0]  ch;
        case (r)
            7: vowels = 40'hE0E8ECF2F9;
            8: vowels = 40'hE2EAEEF4FB;
            9: vowels = 40'hE4EBEFF6FC;
            10: vowels = 40'hE1E9EDF3FA;
            default: vowels = '0;
        endcase
        if ((r == 11 && c == 1) || (r != 11 && c == 5))
            return row_char(r, sh);
        ch = (r == 11) ? 8'hF1 : vowels[39 - 8 * c -: 8];
        return {8'h00, sh ? ch - 8'h20 : ch};
    endfunction

    function automatic void add_action(logic [2:0] act, logic [15:0] ch);
        key_result_t r;
        r = '0;
        r.action = act;
        r.char_code = ch;
        if (event_acts.size() < 2)
            event_acts = {event_acts, r};
    endfunction

    function automatic void emit_char(logic [15:0] ch);
        if (ch == CH_RAQUO)
            add_action(ACT_CHAR, CH_NBSP);
        add_action(ACT_CHAR, ch);
        if (ch == CH_LAQUO)
            add_action(ACT_CHAR, CH_NBSP);
    endfunction

    function automatic void remember_key(logic [7:0] k);
        if (eaten_keys.size() < SWALLOW_DEPTH)
            eaten_keys = {eaten_keys, k};
    endfunction

    function automatic bit key_pressed(logic [7:0] k, bit sh, bit lc, bit rem);
        int r;
        if (k == KEY_APPS && !rem) begin
            menu_down = 1'b1;
            menu_tap = 1'b1;
            return 1'b1;
        end
        menu_tap = 1'b0;
        if (k == KEY_RALT) begin
            ralt_down = 1'b1;
            if (!lc) begin
                lctrl_forced = 1'b1;
                add_action(ACT_CTRL_DOWN, 16'h0000);
            end
            return 1'b0;
        end
        if (!((k >= KEY_ALNUM_LO && k <= KEY_ALNUM_HI) || (k >= KEY_PAD_LO && k <= KEY_PAD_HI) ||
              (k >= KEY_OEM_LO && k <= KEY_OEM_HI) || k == KEY_SPACE))
            return 1'b0;
        if (!dead_armed) begin
            if (!(ralt_down || menu_down))
                return 1'b0;
            for (int i = 0; i < ENTRY_LIMIT; i++) begin
                if (row_key(i) == k) begin
                    if (outcome_count(i) == 0) begin
                        emit_char(row_char(i, sh));
                    end else begin
                        dead_row = i;
                        dead_armed = 1'b1;
                    end
                    remember_key(k);
                    return 1'b1;
                end
            end
            return 1'b0;
        end
        r = dead_row;
        dead_armed = 1'b0;
        dead_row = 0;
        for (int c = 0; c < outcome_count(r); c++) begin
            if (outcome_key(r, c) == k) begin
                emit_char(outcome_char(r, c, sh));
                remember_key(k);
                return 1'b1;
            end
        end
        emit_char(row_char(r, sh));
        return 1'b0;
    endfunction

    function automatic bit key_released(logic [7:0] k, bit rem);
        if (k == KEY_APPS && !rem) begin
            if (menu_down && menu_tap)
                add_action(ACT_MENU_TAP, 16'h0000);
            menu_down = 1'b0;
            menu_tap = 1'b0;
            return 1'b1;
        end
        if (k == KEY_RALT) begin
            ralt_down = 1'b0;
            if (lctrl_forced) begin
                lctrl_forced = 1'b0;
                add_action(ACT_CTRL_UP, 16'h0000);
            end
            return 1'b0;
        end
        for (int i = 0; i < eaten_keys.size(); i++) begin
            if (eaten_keys[i] == k) begin
                eaten_keys.delete(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void translate_event(logic [1:0] kind, logic [7:0] k, bit sh, bit lc,
                                            bit rem);
        bit          sw;
        key_result_t r;
        sw = 1'b0;
        event_acts.delete();
        case (kind)
            KIND_DOWN: sw = key_pressed(k, sh, lc, rem);
            KIND_UP: sw = key_released(k, rem);
            KIND_CANCEL: begin
                dead_armed = 1'b0;
                dead_row = 0;
            end
            default: ;
        endcase
        if (event_acts.size() == 0)
            add_action(ACT_NONE, 16'h0000);
        for (int i = 0; i < event_acts.size(); i++) begin
            r = event_acts[i];
            r.swallow = sw;
            r.last = (i == event_acts.size() - 1);
            due_results = {due_results, r};
        end
    endfunction

    task automatic send_event(logic [1:0] kind, logic [7:0] k, bit sh, bit lc, bit rem);
        int gap;
        s_tdata <= {5'b0, rem, lc, sh, k};
        s_tuser <= kind;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        translate_event(kind, k, sh, lc, rem);
        if (kind != KIND_UNUSED)
            events_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (RELEASE_WAIT) @(posedge aclk);
    endtask

    task automatic test_field_extremes();
        send_event(KIND_UNUSED, 8'hFF, 1, 1, 1);
        send_event(KIND_DOWN, 8'h00, 0, 0, 0);
        send_event(KIND_UP, 8'hFF, 1, 1, 1);
        send_event(KIND_CANCEL, 8'h00, 0, 0, 0);
    endtask

    task automatic test_ralt_ctrl();
        send_event(KIND_DOWN, KEY_RALT, 0, 0, 0);
        send_event(KIND_DOWN, KEY_RALT, 0, 0, 0);
        send_event(KIND_UP, KEY_RALT, 0, 0, 0);
        send_event(KIND_DOWN, KEY_RALT, 0, 1, 0);
        send_event(KIND_UP, KEY_RALT, 0, 1, 0);
    endtask

    task automatic test_direct_chars();
        send_event(KIND_DOWN, KEY_RALT, 0, 1, 0);
        send_event(KIND_DOWN, 8'h00, 0, 1, 0);
        send_event(KIND_DOWN, 8'h45, 0, 1, 0);
        send_event(KIND_DOWN, 8'h43, 1, 1, 0);
        send_event(KIND_DOWN, 8'hDB, 0, 1, 0);
        send_event(KIND_DOWN, 8'hDD, 1, 1, 0);
        send_event(KIND_DOWN, 8'hBA, 0, 1, 0);
        send_event(KIND_DOWN, KEY_SPACE, 0, 1, 0);
    endtask

    task automatic test_dead_keys();
        send_event(KIND_DOWN, 8'h55, 0, 1, 0);
        send_event(KIND_DOWN, 8'h41, 1, 1, 0);
        send_event(KIND_DOWN, 8'h4E, 0, 1, 0);
        send_event(KIND_DOWN, 8'h4E, 0, 1, 0);
        send_event(KIND_UP, 8'h4E, 0, 1, 0);
        send_event(KIND_DOWN, 8'h4F, 0, 1, 0);
        send_event(KIND_DOWN, 8'h58, 0, 1, 0);
        send_event(KIND_DOWN, 8'h50, 0, 1, 0);
        send_event(KIND_CANCEL, 8'h50, 0, 1, 0);
        send_event(KIND_DOWN, 8'h45, 1, 1, 0);
        send_event(KIND_UP, KEY_RALT, 0, 1, 0);
    endtask

    task automatic test_menu_key();
        send_event(KIND_DOWN, KEY_APPS, 0, 0, 0);
        send_event(KIND_UP, KEY_APPS, 0, 0, 0);
        send_event(KIND_DOWN, KEY_APPS, 0, 0, 0);
        send_event(KIND_DOWN, 8'h49, 0, 0, 0);
        send_event(KIND_DOWN, 8'h45, 0, 0, 0);
        send_event(KIND_UP, KEY_APPS, 0, 0, 0);
        send_event(KIND_DOWN, KEY_APPS, 0, 0, 1);
        send_event(KIND_UP, KEY_APPS, 0, 0, 1);
    endtask

    task automatic test_swallow_overflow();
        bit lc;
        lc = 1'($urandom_range(0, 1));
        send_event(KIND_DOWN, KEY_RALT, 0, lc, 0);
        repeat (SWALLOW_DEPTH + 3)
            send_event(KIND_DOWN, row_key($urandom_range(0, 6)), 1'($urandom_range(0, 1)), lc, 0);
        while (eaten_keys.size() != 0)
            send_event(KIND_UP, eaten_keys[$urandom_range(0, eaten_keys.size() - 1)], 0, lc, 0);
        send_event(KIND_UP, row_key($urandom_range(0, 6)), 0, lc, 0);
        send_event(KIND_UP, KEY_RALT, 0, lc, 0);
    endtask

    task automatic compose_sequence();
        bit         lc;
        bit         rem;
        logic [7:0] modifier;
        logic [7:0] k;
        lc = 1'($urandom_range(0, 1));
        rem = ($urandom_range(0, 7) == 0);
        modifier = ($urandom_range(0, 2) == 0) ? KEY_APPS : KEY_RALT;
        send_event(KIND_DOWN, modifier, 1'($urandom_range(0, 1)), lc, rem);
        repeat ($urandom_range(1, 3)) begin
            k = ($urandom_range(0, 9) < 7) ? row_key($urandom_range(0, ENTRY_LIMIT - 1))
                                            : 8'($urandom_range(0, 255));
            send_event(KIND_DOWN, k, 1'($urandom_range(0, 1)), lc, rem);
            if ($urandom_range(0, 1))
                send_event(KIND_UP, k, 0, lc, rem);
            if ($urandom_range(0, 9) == 0)
                send_event(KIND_CANCEL, 8'($urandom_range(0, 255)), 0, lc, rem);
            if ($urandom_range(0, 4) != 0) begin
                k = ($urandom_range(0, 9) < 7) ? outcome_key($urandom_range(7, 11),
                                                             $urandom_range(0, 5))
                                                : 8'($urandom_range(0, 255));
                send_event(KIND_DOWN, k, 1'($urandom_range(0, 1)), lc, rem);
                if ($urandom_range(0, 1))
                    send_event(KIND_UP, k, 0, lc, rem);
            end
        end
        send_event(KIND_UP, modifier, 0, lc, rem);
    endtask

    task automatic test_random_typing(int target);
        int start;
        start = events_sent;
        while (events_sent - start < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: compose_sequence();
                6, 7: repeat ($urandom_range(1, 4))
                    send_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                default: begin
                    if (eaten_keys.size() != 0)
                        send_event(KIND_UP, eaten_keys[$urandom_range(0, eaten_keys.size() - 1)],
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 0);
                end
            endcase
        end
    endtask

    task automatic test_receiver_holdoff();
        hold_request = HOLD_OFF_CYCLES;
        repeat (10) compose_sequence();
        wait_drained();
    endtask

    // receiver: changing stall patterns, plus a long hold-off on request
    int hold_left = 0;
    int pattern_left = 0;
    int stall_pattern = 0;
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (pattern_left == 0) begin
            pattern_left = $urandom_range(16, 256);
            stall_pattern = $urandom_range(0, 3);
        end
        pattern_left--;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (stall_pattern)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t ERROR %s: expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        key_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                $display("%0t ERROR unexpected transaction: expected none got action %0h char %0h",
                         $time, m_tuser, m_tdata[15:0]);
                errors++;
            end else begin
                want = due_results.pop_front();
                compare_field("action", 16'(want.action), 16'(m_tuser));
                compare_field("char_code", want.char_code, m_tdata[15:0]);
                compare_field("swallow", 16'(want.swallow), 16'(m_tdata[16]));
                compare_field("last", 16'(want.last), 16'(m_tlast));
            end
        end
    end

    initial begin : watchdog
        int idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (!s_tvalid && due_results.size() == 0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t ERROR no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        dead_row = 0;
        dead_armed = 1'b0;
        ralt_down = 1'b0;
        menu_down = 1'b0;
        menu_tap = 1'b0;
        lctrl_forced = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_ralt_ctrl();
        test_direct_chars();
        test_dead_keys();
        test_menu_key();
        wait_drained();
        test_swallow_overflow();
        test_random_typing(RANDOM_EVENTS / 2);
        wait_drained();
        test_receiver_holdoff();
        test_random_typing(RANDOM_EVENTS / 2);
        wait_drained();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
